@@ hw/rtl/tspt_pkg.sv @@
// Shared types and constants of the timed setpoint table player.
package tspt_pkg;

   // Number of position lanes carried by one result word.
   localparam int RSP_LANES = 4;
   localparam int RSP_POS_WIDTH = 32;

   // Register reset values.
   localparam logic [15:0] TPS_RESET   = 16'd1000;
   localparam logic [6:0]  STEPS_RESET = 7'd1;
   localparam logic [2:0]  CHANS_RESET = 3'd4;

   // Item kinds carried in the request user field.
   typedef enum logic [1:0] {
      MODE_TICK      = 2'd0,
      MODE_LOAD_TIME = 2'd1,
      MODE_LOAD_POS  = 2'd2,
      MODE_START     = 2'd3
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_TICKS_PER_SECOND = 2'd0,
      CSR_STEPS_IN_USE     = 2'd1,
      CSR_CHANNELS_IN_USE  = 2'd2
   } csr_index_type;

   // One result word as it waits in the output queue.
   typedef struct packed {
      logic [RSP_LANES-1:0][RSP_POS_WIDTH-1:0] pos;
      logic                                    finished;
      logic                                    last;
   } rsp_word_type;

   // Up to two result words pushed by one evaluated tick.
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } rsp_push_type;

endpackage

@@ hw/rtl/tspt_time_mem.sv @@
// Time table memory: one write port and two registered read ports.
module tspt_time_mem #(
   parameter int STEPS = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(STEPS)-1:0] wr_addr,
   input  logic [31:0]              wr_data,
   input  logic [$clog2(STEPS)-1:0] rd_addr_a,
   input  logic [$clog2(STEPS)-1:0] rd_addr_b,
   output logic [31:0]              rd_data_a,
   output logic [31:0]              rd_data_b
);

   logic [31:0] mem_ff [STEPS];
   logic [31:0] rd_data_a_ff;
   logic [31:0] rd_data_b_ff;

   // Synchronous write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Both read ports are registered: data appears in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ hw/rtl/tspt_pos_mem.sv @@
// Position table memory: one row per step, one lane per channel, lane writes.
module tspt_pos_mem #(
   parameter int STEPS     = 64,
   parameter int CHANNELS  = 4,
   parameter int POS_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(STEPS)-1:0]            wr_addr,
   input  logic [CHANNELS-1:0]                 wr_lane_sel,
   input  logic [POS_WIDTH-1:0]                wr_data,
   input  logic [$clog2(STEPS)-1:0]            rd_addr,
   output logic [CHANNELS-1:0][POS_WIDTH-1:0]  rd_row
);

   logic [CHANNELS-1:0][POS_WIDTH-1:0] mem_ff [STEPS];
   logic [CHANNELS-1:0][POS_WIDTH-1:0] rd_row_ff;

   // Each lane of the addressed row is written only when selected.
   always_ff @(posedge clock) begin
      for (int l = 0; l < CHANNELS; l++) begin
         if (wr_en && wr_lane_sel[l]) begin
            mem_ff[wr_addr][l] <= wr_data;
         end
      end
   end

   // The whole row is read through a register and appears in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_row_ff <= mem_ff[rd_addr];
   end

   assign rd_row = rd_row_ff;

endmodule

@@ hw/rtl/tspt_out_queue.sv @@
// Four-word result queue: takes up to two words a cycle, gives one a cycle while the reader is ready.
module tspt_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  tspt_pkg::rsp_push_type push,
   output logic                   space_ok,
   input  logic                   pop_ready,
   output logic                   head_valid,
   output tspt_pkg::rsp_word_type head
);

   import tspt_pkg::*;

   rsp_word_type entry_ff [4];
   logic [1:0]   wr_ptr_ff;
   logic [1:0]   wr_ptr_in;
   logic [1:0]   rd_ptr_ff;
   logic [1:0]   rd_ptr_in;
   logic [2:0]   count_ff;
   logic [2:0]   count_in;
   logic         pop;

   assign head_valid = (count_ff != 3'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign pop        = head_valid && pop_ready;
   // Room for the two words that one tick may produce.
   assign space_ok   = (count_ff <= 3'd2);

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

endmodule

@@ hw/rtl/timed_setpoint_table_player.sv @@
// Top level of the timed setpoint table player.
// While the run is open, each tick word counts toward whole seconds and checks the
// seconds count against the final time and the next step's time, producing zero, one or
// two result words; load words fill the time and position tables and a start word
// restarts the run. Configuration words are taken one per cycle, load and start words
// too while the queue has room. In a tick's accept cycle the time table (final entry and
// next step) and the next step's position row are read; in the following cycle the
// compare updates the step index and finished flag while no new word is accepted.
// Result words wait in a four-word queue, and a request word of any kind is accepted
// only when two words are free in it. Tables hold no reset value; no clearing pass runs.
module timed_setpoint_table_player #(
   parameter int CHANNELS  = 4,
   parameter int STEPS     = 64,
   parameter int POS_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   // Request channel.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,  // entry_index[5:0], channel[7:6], value[39:8]
   input  logic [1:0]    req_tuser,  // mode[1:0]
   // Result channel.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,  // pos_0[31:0], pos_1[63:32], pos_2[95:64], pos_3[127:96]
   output logic          rsp_tuser,  // run_finished[0]
   output logic          rsp_tlast,
   // Configuration write channel.
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   import tspt_pkg::*;

   localparam int AW  = $clog2(STEPS);
   localparam int SW  = $clog2(STEPS + 1);
   localparam int SCW = (SW > 7) ? SW : 7;

   // Configuration registers.
   logic [15:0]  tps_ff;
   logic [15:0]  tps_in;
   logic [6:0]   steps_ff;
   logic [6:0]   steps_in;
   logic [2:0]   chans_ff;
   logic [2:0]   chans_in;

   // Run state.
   logic [15:0]  tick_ff;
   logic [15:0]  tick_in;
   logic [31:0]  sec_ff;
   logic [31:0]  sec_in;
   logic [SW-1:0] next_step_ff;
   logic [SW-1:0] next_step_in;
   logic         fin_ff;
   logic         fin_in;
   logic         eval_vld_ff;
   logic         eval_vld_in;

   // Request decode.
   logic         req_acc;
   logic         csr_acc;
   mode_type     req_mode;
   logic [5:0]   req_idx;
   logic [1:0]   req_ch;
   logic [31:0]  req_value;
   logic [15:0]  tick_inc;

   // Table access.
   logic         time_wr_en;
   logic [31:0]  time_wr_data;
   logic         pos_wr_en;
   logic [CHANNELS-1:0] pos_wr_sel;
   logic [POS_WIDTH+31:0] pos_wr_wide;
   logic [SCW-1:0] steps_ext;
   logic [SW-1:0] steps_used;
   logic [SW-1:0] last_step;
   logic [31:0]  last_time;
   logic [31:0]  step_time;
   logic [CHANNELS-1:0][POS_WIDTH-1:0] step_row;

   // Evaluation.
   logic [3:0]   chans_ext;
   logic [3:0]   chans_used;
   logic         fin_hit;
   logic         step_hit;
   logic [RSP_LANES-1:0][RSP_POS_WIDTH-1:0] row_pos;
   rsp_word_type zero_word;
   rsp_word_type row_word;
   rsp_push_type push;
   logic         space_ok;
   rsp_word_type head;

   assign req_mode  = mode_type'(req_tuser);
   assign req_idx   = req_tdata[5:0];
   assign req_ch    = req_tdata[7:6];
   assign req_value = req_tdata[39:8];

   assign req_tready = !eval_vld_ff && space_ok;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_acc    = csr_valid && csr_ready;

   // Configuration writes.
   always_comb begin
      tps_in   = tps_ff;
      steps_in = steps_ff;
      chans_in = chans_ff;
      if (csr_acc) begin
         case (csr_index_type'(csr_index))
            CSR_TICKS_PER_SECOND: tps_in   = csr_wdata;
            CSR_STEPS_IN_USE:     steps_in = csr_wdata[6:0];
            CSR_CHANNELS_IN_USE:  chans_in = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Effective step and channel counts.
   always_comb begin
      steps_ext = SCW'(steps_ff);
      if (steps_ext == '0) begin
         steps_used = SW'(1);
      end else if (steps_ext > SCW'(STEPS)) begin
         steps_used = SW'(STEPS);
      end else begin
         steps_used = SW'(steps_ext);
      end
      last_step = steps_used - SW'(1);
      chans_ext  = {1'b0, chans_ff};
      chans_used = (chans_ext > 4'(CHANNELS)) ? 4'(CHANNELS) : chans_ext;
   end

   // Table writes from load words.
   always_comb begin
      time_wr_en   = req_acc && (req_mode == MODE_LOAD_TIME) && (32'(req_idx) < STEPS);
      time_wr_data = req_value[31] ? 32'd0 : req_value;
      pos_wr_en    = req_acc && (req_mode == MODE_LOAD_POS) && (32'(req_idx) < STEPS) &&
                     (32'(req_ch) < CHANNELS);
      pos_wr_wide  = {{POS_WIDTH{req_value[31]}}, req_value};
      for (int l = 0; l < CHANNELS; l++) begin
         pos_wr_sel[l] = (32'(req_ch) == l);
      end
   end

   tspt_time_mem #(
      .STEPS(STEPS)
   ) u_time_mem (
      .clock     (clock),
      .wr_en     (time_wr_en),
      .wr_addr   (AW'(req_idx)),
      .wr_data   (time_wr_data),
      .rd_addr_a (last_step[AW-1:0]),
      .rd_addr_b (next_step_ff[AW-1:0]),
      .rd_data_a (last_time),
      .rd_data_b (step_time)
   );

   tspt_pos_mem #(
      .STEPS     (STEPS),
      .CHANNELS  (CHANNELS),
      .POS_WIDTH (POS_WIDTH)
   ) u_pos_mem (
      .clock       (clock),
      .wr_en       (pos_wr_en),
      .wr_addr     (AW'(req_idx)),
      .wr_lane_sel (pos_wr_sel),
      .wr_data     (pos_wr_wide[POS_WIDTH-1:0]),
      .rd_addr     (next_step_ff[AW-1:0]),
      .rd_row      (step_row)
   );

   // Compare the seconds count with the table times read in the accept cycle.
   assign fin_hit  = (sec_ff >= last_time);
   assign step_hit = (next_step_ff < steps_used) && (sec_ff >= step_time);

   // Lanes beyond the channels in use read as zero; stored width maps onto 32 bits.
   for (genvar j = 0; j < RSP_LANES; j++) begin : g_lane
      if (j < CHANNELS) begin : g_used
         logic [POS_WIDTH+31:0] lane_wide;
         assign lane_wide  = {32'd0, step_row[j]};
         assign row_pos[j] = (4'(j) < chans_used) ? lane_wide[31:0] : 32'd0;
      end else begin : g_none
         assign row_pos[j] = 32'd0;
      end
   end

   // Build the result words of an evaluated tick.
   always_comb begin
      zero_word          = '0;
      zero_word.finished = 1'b1;
      zero_word.last     = 1'b1;
      row_word           = '0;
      row_word.pos       = row_pos;
      row_word.finished  = fin_hit;
      row_word.last      = 1'b1;
      push               = '0;
      if (eval_vld_ff) begin
         if (fin_ff) begin
            push.count = 2'd1;
            push.first = zero_word;
         end else if (fin_hit && step_hit) begin
            push.count      = 2'd2;
            push.first      = zero_word;
            push.first.last = 1'b0;
            push.second     = row_word;
         end else if (fin_hit) begin
            push.count = 2'd1;
            push.first = zero_word;
         end else if (step_hit) begin
            push.count = 2'd1;
            push.first = row_word;
         end
      end
   end

   // Run state: prescaler on accept, step and finish updates in the evaluate cycle.
   always_comb begin
      tick_in      = tick_ff;
      sec_in       = sec_ff;
      next_step_in = next_step_ff;
      fin_in       = fin_ff;
      eval_vld_in  = 1'b0;
      tick_inc     = tick_ff + 16'd1;
      if (req_acc) begin
         case (req_mode)
            MODE_TICK: begin
               eval_vld_in = 1'b1;
               if (!fin_ff) begin
                  if (tick_inc >= tps_ff) begin
                     tick_in = 16'd0;
                     if (sec_ff != 32'hFFFF_FFFF) begin
                        sec_in = sec_ff + 32'd1;
                     end
                  end else begin
                     tick_in = tick_inc;
                  end
               end
            end
            MODE_START: begin
               tick_in      = 16'd0;
               sec_in       = 32'd0;
               next_step_in = '0;
               fin_in       = 1'b0;
            end
            default: ;
         endcase
      end
      if (eval_vld_ff && !fin_ff) begin
         if (fin_hit) begin
            fin_in = 1'b1;
         end
         if (step_hit) begin
            next_step_in = next_step_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TPS_RESET;
         steps_ff     <= STEPS_RESET;
         chans_ff     <= CHANS_RESET;
         tick_ff      <= 16'd0;
         sec_ff       <= 32'd0;
         next_step_ff <= '0;
         fin_ff       <= 1'b0;
         eval_vld_ff  <= 1'b0;
      end else begin
         tps_ff       <= tps_in;
         steps_ff     <= steps_in;
         chans_ff     <= chans_in;
         tick_ff      <= tick_in;
         sec_ff       <= sec_in;
         next_step_ff <= next_step_in;
         fin_ff       <= fin_in;
         eval_vld_ff  <= eval_vld_in;
      end
   end

   tspt_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_ok   (space_ok),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = head.pos;
   assign rsp_tuser = head.finished;
   assign rsp_tlast = head.last;

`ifndef SYNTHESIS
   // No word may enter while a tick is being evaluated.
   a_eval_blocks_input: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> !req_tready)
      else $error("word accepted during tick evaluation");

   // An accepted tick is evaluated in the next cycle.
   a_tick_evaluates: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_mode == MODE_TICK)) |=> eval_vld_ff)
      else $error("accepted tick was not evaluated");

   // A finished run stays finished until a start word.
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (fin_ff && !(req_acc && (req_mode == MODE_START))) |=> fin_ff)
      else $error("finished flag dropped without a start");

   // The step index never runs past the table.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(next_step_ff) <= STEPS))
      else $error("step index beyond table");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the timed setpoint table player.
module testbench;
   import tspt_pkg::*;

   // Cycles with no handshake on any channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 4000;
   // Cycles allowed for a load or tick still in flight once nothing is expected.
   localparam int SETTLE_CYCLES = 8;
   // Request words generated per random phase.
   localparam int PHASE_WORDS = 120;

   // One request word as the driver sends it.
   typedef struct packed {
      mode_type    mode;
      logic [5:0]  entry;
      logic [1:0]  lane;
      logic [31:0] value;
   } command_word_t;

   // One predicted result word.
   typedef struct packed {
      logic [3:0][31:0] pos;
      logic             finished;
      logic             last_of_tick;
   } setpoint_word_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   timed_setpoint_table_player DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Player state as the testbench predicts it.
   logic [15:0]      tps_cfg = TPS_RESET;
   logic [6:0]       steps_cfg = STEPS_RESET;
   logic [2:0]       chans_cfg = CHANS_RESET;
   logic [15:0]      tick_cnt = '0;
   logic [31:0]      sec_cnt = '0;
   logic [6:0]       step_ptr = '0;
   logic             run_done = 1'b0;
   logic [3:0][31:0] held = '0;
   logic [31:0]      time_tab [64];
   logic [31:0]      pos_tab [64][4];

   command_word_t  pending_words [$];
   setpoint_word_t expected_setpoints [$];
   command_word_t  word_on_bus;
   setpoint_word_t want;

   int send_idle_pct = 9;
   int recv_idle_pct = 59;
   int mismatch_count = 0;
   int words_taken = 0;
   int ticks_taken = 0;
   int words_checked = 0;
   int quiet_cycles = 0;
   int phase_words;

   // Snapshot of the held positions as one result word.
   function automatic setpoint_word_t held_word();
      setpoint_word_t w;
      w.pos = held;
      w.finished = run_done;
      w.last_of_tick = 1'b0;
      return w;
   endfunction

   // Advance the predicted player by one accepted request word.
   function automatic void play_word(command_word_t w);
      setpoint_word_t res [2];
      int n;
      int steps;
      int lanes;
      n = 0;
      case (w.mode)
         MODE_LOAD_TIME: time_tab[w.entry] = w.value[31] ? 32'd0 : w.value;
         MODE_LOAD_POS: pos_tab[w.entry][w.lane] = w.value;
         MODE_START: begin
            tick_cnt = '0;
            sec_cnt = '0;
            step_ptr = '0;
            run_done = 1'b0;
            held = '0;
         end
         default: begin
            if (run_done) begin
               held = '0;
               res[n] = held_word();
               n++;
            end else begin
               steps = (steps_cfg == 0) ? 1 : (steps_cfg > 64 ? 64 : int'(steps_cfg));
               lanes = (chans_cfg > 4) ? 4 : int'(chans_cfg);
               tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt >= tps_cfg) begin
                  tick_cnt = '0;
                  if (sec_cnt != '1) sec_cnt = sec_cnt + 32'd1;
               end
               // Reaching the final time closes the run with an all-zero word.
               if (sec_cnt >= time_tab[steps-1]) begin
                  run_done = 1'b1;
                  held = '0;
                  res[n] = held_word();
                  n++;
               end
               // The next step may still be emitted in the same tick.
               if (int'(step_ptr) < steps && sec_cnt >= time_tab[step_ptr[5:0]]) begin
                  for (int i = 0; i < 4; i++)
                     held[i] = (i < lanes) ? pos_tab[step_ptr[5:0]][i] : 32'd0;
                  res[n] = held_word();
                  n++;
                  step_ptr = step_ptr + 7'd1;
               end
            end
            if (n > 0) res[n-1].last_of_tick = 1'b1;
            for (int k = 0; k < n; k++) expected_setpoints.push_back(res[k]);
         end
      endcase
   endfunction

   function automatic void send_word(mode_type mode, logic [5:0] entry, logic [1:0] lane,
                                     logic [31:0] value);
      command_word_t w;
      w.mode = mode;
      w.entry = entry;
      w.lane = lane;
      w.value = value;
      pending_words.push_back(w);
      phase_words++;
   endfunction

   function automatic void flag_error(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
   endfunction

   // Request driver: predicts each accepted word and presents the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            play_word(word_on_bus);
            words_taken++;
            if (word_on_bus.mode == MODE_TICK) ticks_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               word_on_bus = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {word_on_bus.value, word_on_bus.lane, word_on_bus.entry};
               req_tuser <= word_on_bus.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each accepted word with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_setpoints.size() == 0) begin
               flag_error($sformatf("result word with none expected, data %h", rsp_tdata));
            end else begin
               want = expected_setpoints.pop_front();
               for (int j = 0; j < 4; j++)
                  if (rsp_tdata[32*j +: 32] !== want.pos[j])
                     flag_error($sformatf("pos_%0d expected %h got %h",
                                          j, want.pos[j], rsp_tdata[32*j +: 32]));
               if (rsp_tuser !== want.finished)
                  flag_error($sformatf("run_finished expected %b got %b",
                                       want.finished, rsp_tuser));
               if (rsp_tlast !== want.last_of_tick)
                  flag_error($sformatf("last expected %b got %b", want.last_of_tick, rsp_tlast));
               words_checked++;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Wait until every word is sent and every result has arrived, then let the block settle.
   // The check runs on the falling edge, when the driver and monitor have settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_setpoints.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back, holding valid high between words.
   task automatic write_config(logic [15:0] tps, logic [6:0] steps, logic [2:0] chans);
      csr_index_type idx [3];
      logic [15:0] data [3];
      idx = '{CSR_TICKS_PER_SECOND, CSR_STEPS_IN_USE, CSR_CHANNELS_IN_USE};
      data = '{tps, {9'd0, steps}, {13'd0, chans}};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= data[k];
         do @(posedge clock);
         while (!csr_ready);
         case (idx[k])
            CSR_TICKS_PER_SECOND: tps_cfg = data[k];
            CSR_STEPS_IN_USE: steps_cfg = data[k][6:0];
            default: chans_cfg = data[k][2:0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // A well-formed run most of the time: some table loads, a start, then ticks.
   task automatic queue_run();
      int r;
      repeat ($urandom_range(0, 4)) begin
         r = $urandom_range(0, 99);
         if (r < 85)
            send_word(MODE_LOAD_TIME, 6'($urandom_range(0, 63)), 2'($urandom),
                      32'($urandom_range(0, 12)));
         else if (r < 93)
            send_word(MODE_LOAD_TIME, 6'($urandom_range(0, 63)), 2'($urandom),
                      {1'b1, 31'($urandom)});
         else
            send_word(MODE_LOAD_TIME, 6'($urandom_range(0, 63)), 2'($urandom), $urandom);
      end
      repeat ($urandom_range(0, 6))
         send_word(MODE_LOAD_POS, 6'($urandom_range(0, 63)), 2'($urandom), $urandom);
      if ($urandom_range(0, 9) < 8) send_word(MODE_START, 6'($urandom), 2'($urandom), $urandom);
      repeat ($urandom_range(1, 24)) send_word(MODE_TICK, 6'($urandom), 2'($urandom), $urandom);
   endtask

   initial begin
      logic [15:0] tps_set [6];
      logic [6:0]  steps_set [6];
      logic [2:0]  chans_set [6];
      tps_set = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd2};
      steps_set = '{7'd4, 7'd64, 7'd0, 7'd127, 7'd9, 7'd3};
      chans_set = '{3'd4, 3'd3, 3'd7, 3'd0, 3'd1, 3'd2};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Fill both tables so that no tick ever reads an unwritten entry.
      for (int i = 0; i < 64; i++) send_word(MODE_LOAD_TIME, 6'(i), 2'd0, 32'(i));
      for (int i = 0; i < 64; i++)
         for (int c = 0; c < 4; c++) send_word(MODE_LOAD_POS, 6'(i), 2'(c), $urandom);

      // Reset settings: a negative time clamps to zero, so the first tick both
      // finishes the run and emits step zero; later ticks emit zeros.
      send_word(MODE_LOAD_TIME, 6'd0, 2'd0, 32'h8000_0000);
      send_word(MODE_LOAD_POS, 6'd0, 2'd0, 32'h7fff_ffff);
      send_word(MODE_LOAD_POS, 6'd0, 2'd1, 32'h8000_0000);
      send_word(MODE_LOAD_POS, 6'd0, 2'd2, 32'hffff_ffff);
      send_word(MODE_LOAD_POS, 6'd63, 2'd3, 32'h0000_0000);
      send_word(MODE_START, 6'd0, 2'd0, 32'd0);
      send_word(MODE_TICK, 6'd0, 2'd0, 32'd0);
      send_word(MODE_TICK, 6'h3f, 2'd3, 32'hffff_ffff);
      send_word(MODE_START, 6'h3f, 2'd3, 32'hffff_ffff);
      send_word(MODE_TICK, 6'd0, 2'd0, 32'd0);
      wait_idle();

      // Unreachable final time keeps the run open while steps go out one per second.
      write_config(16'd1, 7'd5, 3'd2);
      send_word(MODE_LOAD_TIME, 6'd4, 2'd0, 32'h7fff_ffff);
      send_word(MODE_START, 6'd0, 2'd0, 32'd0);
      repeat (6) send_word(MODE_TICK, 6'd0, 2'd0, 32'd0);
      wait_idle();

      // Fewer steps in use than the step index already reached: only the finish fires.
      write_config(16'd1, 7'd2, 3'd2);
      repeat (2) send_word(MODE_TICK, 6'd0, 2'd0, 32'd0);
      wait_idle();

      // Slowest prescaler, no channels driven, clamped final time.
      write_config(16'hffff, 7'd64, 3'd0);
      send_word(MODE_LOAD_TIME, 6'd63, 2'd0, -32'sd5);
      send_word(MODE_START, 6'd0, 2'd0, 32'd0);
      repeat (2) send_word(MODE_TICK, 6'd0, 2'd0, 32'd0);
      wait_idle();

      // Random runs under six register settings and three idling patterns.
      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 9 : (p < 4) ? 59 : 0;
         recv_idle_pct = (p < 2) ? 59 : (p < 4) ? 9 : 0;
         write_config(tps_set[p], steps_set[p], chans_set[p]);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) queue_run();
         wait_idle();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d request words (%0d ticks) and %0d result words", words_taken,
               ticks_taken, words_checked);
      $display("over ten register settings, with %0d mismatches", mismatch_count);
      if (mismatch_count == 0 && expected_setpoints.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/tspt_pkg.sv
hw/rtl/tspt_time_mem.sv
hw/rtl/tspt_pos_mem.sv
hw/rtl/tspt_out_queue.sv
hw/rtl/timed_setpoint_table_player.sv
dv/testbench.sv
